@@ sv/bu2x_pkg.sv @@
// bu2x_pkg: shared types and constants for the 2x bilinear upscaler.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bu2x_pkg;

   // Field widths fixed by the interface
   localparam int CHAN_W  = 8;
   localparam int CFG_W   = 11;
   localparam int COORD_W = 11;

   // Register reset values
   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   // Register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_SOURCE_WIDTH  = 1'b0,
      CSR_SOURCE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // Four interpolated pixels of one 2x2 neighborhood
   typedef struct packed {
      pixel_type corner;
      pixel_type horiz;
      pixel_type vert;
      pixel_type center;
   } quad_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic [CHAN_W-1:0]  red_out;
      logic [CHAN_W-1:0]  green_out;
      logic [CHAN_W-1:0]  blue_out;
      logic               last_of_run;
   } rsp_type;

endpackage

`default_nettype wire

@@ sv/bu2x_linebuf.sv @@
// bu2x_linebuf: line buffer holding the previous source row.
// Depends on bu2x_pkg. One port, read-before-write, registered read data.
`default_nettype none

module bu2x_linebuf #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [AW-1:0]        addr,
   input  wire bu2x_pkg::pixel_type  wdata,
   output      bu2x_pkg::pixel_type  rdata
);
   import bu2x_pkg::*;

   pixel_type mem [DEPTH];
   pixel_type rdata_ff;

   // Old contents come out while the new pixel goes in
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff  <= mem[addr];
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/bu2x_interp.sv @@
// bu2x_interp: averages of one 2x2 neighborhood, truncated per channel.
// Depends on bu2x_pkg. Pure combinational logic.
`default_nettype none

module bu2x_interp (
   input  wire bu2x_pkg::pixel_type p00,
   input  wire bu2x_pkg::pixel_type p01,
   input  wire bu2x_pkg::pixel_type p10,
   input  wire bu2x_pkg::pixel_type p11,
   output      bu2x_pkg::quad_type  quad
);
   import bu2x_pkg::*;

   function automatic logic [CHAN_W-1:0] avg2(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
      logic [CHAN_W:0] sum;
      sum  = {1'b0, a} + {1'b0, b};
      avg2 = sum[CHAN_W:1];
   endfunction

   function automatic logic [CHAN_W-1:0] avg4(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] d,
                                              input logic [CHAN_W-1:0] e);
      logic [CHAN_W+1:0] sum;
      sum  = {2'b00, a} + {2'b00, b} + {2'b00, d} + {2'b00, e};
      avg4 = sum[CHAN_W+1:2];
   endfunction

   always_comb begin
      quad.corner       = p00;
      quad.horiz.red    = avg2(p00.red,   p01.red);
      quad.horiz.green  = avg2(p00.green, p01.green);
      quad.horiz.blue   = avg2(p00.blue,  p01.blue);
      quad.vert.red     = avg2(p00.red,   p10.red);
      quad.vert.green   = avg2(p00.green, p10.green);
      quad.vert.blue    = avg2(p00.blue,  p10.blue);
      quad.center.red   = avg4(p00.red,   p01.red,   p10.red,   p11.red);
      quad.center.green = avg4(p00.green, p01.green, p10.green, p11.green);
      quad.center.blue  = avg4(p00.blue,  p01.blue,  p10.blue,  p11.blue);
   end

endmodule

`default_nettype wire

@@ sv/bilinear_upscale_2x.sv @@
// bilinear_upscale_2x: 2x bilinear upscaler, raster-order RGB in, 4 pixels out.
// The source beat is registered in stage A, then in result stage B at the port.
// Flow: a pixel with r>=1 and c>=1 gives four result beats, one per cycle while
// rsp_ready is high; pixels in row 0 or column 0 give no beats and pass through.
// Reset (synchronous): size registers to 640x480, counters and neighbors
// cleared; the line buffer is not cleared and needs no clearing pass.
`default_nettype none

module bilinear_upscale_2x #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire bu2x_pkg::req_type       req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      bu2x_pkg::rsp_type       rsp_data,
   input  wire logic                    csr_we,
   input  wire bu2x_pkg::csr_index_type csr_index,
   input  wire logic [10:0]             csr_wdata
);
   import bu2x_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   typedef enum logic [1:0] {
      BEAT_CORNER = 2'd0,
      BEAT_HORIZ  = 2'd1,
      BEAT_VERT   = 2'd2,
      BEAT_CENTER = 2'd3
   } beat_type;

   // Configuration registers
   logic [CFG_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  width_ff  <= csr_wdata;
            CSR_SOURCE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective frame size, saturated to [2, MAX]
   logic [31:0] width_cfg, height_cfg, width_sat, height_sat;
   logic [CW:0] width_eff;
   logic [RW:0] height_eff;

   always_comb begin
      width_cfg  = 32'(width_ff);
      height_cfg = 32'(height_ff);
      if (width_cfg < 32'd2)             width_sat = 32'd2;
      else if (width_cfg > 32'(MAX_WIDTH)) width_sat = 32'(MAX_WIDTH);
      else                               width_sat = width_cfg;
      if (height_cfg < 32'd2)              height_sat = 32'd2;
      else if (height_cfg > 32'(MAX_HEIGHT)) height_sat = 32'(MAX_HEIGHT);
      else                                 height_sat = height_cfg;
      width_eff  = (CW+1)'(width_sat);
      height_eff = (RW+1)'(height_sat);
   end

   // Pipeline control
   logic     a_valid_ff, b_valid_ff;
   logic     a_emit_ff, a_wrap_ff;
   logic     b_free, a_adv, req_acc;
   beat_type beat_ff;

   assign b_free    = !b_valid_ff || (rsp_ready && beat_ff == BEAT_CENTER);
   assign a_adv     = a_valid_ff && (!a_emit_ff || b_free);
   assign req_ready = !a_valid_ff || a_adv;
   assign req_acc   = req_valid && req_ready;

   // Raster counters, stepped on each accepted beat
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          col_wrap;

   always_comb begin
      col_wrap = ({1'b0, col_ff} + 1'b1) >= width_eff;
      col_in   = col_wrap ? '0 : col_ff + 1'b1;
      row_in   = row_ff;
      if (col_wrap) begin
         row_in = (({1'b0, row_ff} + 1'b1) >= height_eff) ? '0 : row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line buffer: read of the pixel above lands with stage A
   pixel_type cur_pix, above_pix;

   assign cur_pix = '{red: req_data.red_in, green: req_data.green_in,
                      blue: req_data.blue_in};

   bu2x_linebuf #(.DEPTH(MAX_WIDTH), .AW(CW)) u_linebuf (
      .clock (clock),
      .en    (req_acc),
      .addr  (col_ff),
      .wdata (cur_pix),
      .rdata (above_pix)
   );

   // Stage A: accepted source pixel and its position
   pixel_type     a_pix_ff;
   logic [CW-1:0] a_col_ff;
   logic [RW-1:0] a_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_pix_ff  <= cur_pix;
         a_col_ff  <= col_ff;
         a_row_ff  <= row_ff;
         a_emit_ff <= (row_ff != '0) && (col_ff != '0);
         a_wrap_ff <= col_wrap;
      end
   end

   // Left and upper-left neighbors, cleared at row end
   pixel_type left_ff, uleft_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         uleft_ff <= '0;
      end else if (a_adv) begin
         left_ff  <= a_wrap_ff ? '0 : a_pix_ff;
         uleft_ff <= a_wrap_ff ? '0 : above_pix;
      end
   end

   // Interpolation of the closed neighborhood
   quad_type quad;

   bu2x_interp u_interp (
      .p00  (uleft_ff),
      .p01  (above_pix),
      .p10  (left_ff),
      .p11  (a_pix_ff),
      .quad (quad)
   );

   // Stage B: result register, sent as four beats
   quad_type           b_quad_ff;
   logic [COORD_W-1:0] b_row_ff, b_col_ff;
   logic               b_load;

   assign b_load = a_adv && a_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         beat_ff    <= BEAT_CORNER;
      end else begin
         if (b_valid_ff && rsp_ready) begin
            if (beat_ff == BEAT_CENTER) begin
               b_valid_ff <= 1'b0;
            end else begin
               beat_ff <= beat_type'(beat_ff + 2'd1);
            end
         end
         if (b_load) begin
            b_valid_ff <= 1'b1;
            beat_ff    <= BEAT_CORNER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_quad_ff <= quad;
         b_row_ff  <= COORD_W'({a_row_ff - 1'b1, 1'b0});
         b_col_ff  <= COORD_W'({a_col_ff - 1'b1, 1'b0});
      end
   end

   // Output beat select
   always_comb begin
      rsp_data.out_row     = b_row_ff;
      rsp_data.out_col     = b_col_ff;
      rsp_data.red_out     = b_quad_ff.corner.red;
      rsp_data.green_out   = b_quad_ff.corner.green;
      rsp_data.blue_out    = b_quad_ff.corner.blue;
      rsp_data.last_of_run = 1'b0;
      case (beat_ff)
         BEAT_CORNER: ;
         BEAT_HORIZ: begin
            rsp_data.out_col   = b_col_ff + 1'b1;
            rsp_data.red_out   = b_quad_ff.horiz.red;
            rsp_data.green_out = b_quad_ff.horiz.green;
            rsp_data.blue_out  = b_quad_ff.horiz.blue;
         end
         BEAT_VERT: begin
            rsp_data.out_row   = b_row_ff + 1'b1;
            rsp_data.red_out   = b_quad_ff.vert.red;
            rsp_data.green_out = b_quad_ff.vert.green;
            rsp_data.blue_out  = b_quad_ff.vert.blue;
         end
         BEAT_CENTER: begin
            rsp_data.out_row     = b_row_ff + 1'b1;
            rsp_data.out_col     = b_col_ff + 1'b1;
            rsp_data.red_out     = b_quad_ff.center.red;
            rsp_data.green_out   = b_quad_ff.center.green;
            rsp_data.blue_out    = b_quad_ff.center.blue;
            rsp_data.last_of_run = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid = b_valid_ff;

endmodule

`default_nettype wire

@@ sv/bu2x_checker.sv @@
// bu2x_checker: port-level assertions for bilinear_upscale_2x, bound below.
// Depends on bu2x_pkg for the port types.
`default_nettype none

module bu2x_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire bu2x_pkg::rsp_type       rsp_data
);
   import bu2x_pkg::*;

   // Reset empties the result side
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // The closing beat of a run is the odd/odd output pixel
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |->
         rsp_data.out_row[0] && rsp_data.out_col[0])
      else $error("last beat not at odd row and column");

   // Only the closing beat sits at odd row and odd column
   a_mid_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |->
         !(rsp_data.out_row[0] && rsp_data.out_col[0]))
      else $error("non-last beat at odd row and column");

   // A run never breaks off before its closing beat
   a_run_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_run |=> rsp_valid)
      else $error("run of result beats broke off");

endmodule

bind bilinear_upscale_2x bu2x_checker u_bu2x_checker (.*);

`default_nettype wire
